FILE: rtl/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg: shared types and constants for the two-stack queue
// Request and result layouts, status codes and sequencer states.
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int DATA_W      = 32;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_POP_ADDR,
        S_POP
    } state_t;

    typedef struct packed {
        cmd_t                     command;
        logic signed [DATA_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        status_t                  status;
        logic                     now_empty;
    } rsp_t;

endpackage

FILE: rtl/tsq_ram.sv
// ----------------------------------------------------------------------------
// tsq_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/two_stack_queue.sv
// ----------------------------------------------------------------------------
// two_stack_queue: first-in first-out queue built from two stacks
// An input stack takes enqueued words; an output stack serves dequeues and is
// refilled from the input stack, in reversed order, whenever it runs dry.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a request by raising start with req while busy is low; it is taken
//   at that rising edge. Every request gives exactly one result on rsp,
//   marked by done high for a single cycle. The receiver cannot hold results
//   off, so done is a pure strobe and rsp is only meaningful alongside it.
//   Sequence from acceptance to done:
//     - enqueue, or any refused request: done is registered from the idle
//       state, busy stays low, so a request may follow in the very next cycle;
//     - dequeue with words on the output stack: read issued on acceptance,
//       busy only in the pop state, which takes the word and raises done;
//     - dequeue with the output stack empty and words on the input stack:
//       busy through the move, pop-address and pop states, as the words move
//       one per cycle, each once, through the input RAM into the output stack.
//   Reset clears both counts and the sequencer; stack contents are not
//   cleared, since only entries below the counts are ever read.
//   Status: ok, full (input stack holds STACK_DEPTH words, enqueue refused),
//   empty (both stacks empty, dequeue refused); refused requests change no
//   state and return a zero word.
// ----------------------------------------------------------------------------
module two_stack_queue #(
    parameter int STACK_DEPTH = tsq_pkg::STACK_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  tsq_pkg::req_t req,
    output logic          done,
    output tsq_pkg::rsp_t rsp
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int DW     = tsq_pkg::DATA_W;

    tsq_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] in_count_reg, in_count_next;
    logic [CNT_W-1:0] out_count_reg, out_count_next;
    logic             pend_reg, pend_next;
    logic             done_reg, done_next;
    tsq_pkg::rsp_t    rsp_reg, rsp_next;

    // RAM port controls
    logic              in_wr_en;
    logic              in_rd_en;
    logic [ADDR_W-1:0] in_rd_addr;
    logic [DW-1:0]     in_rd_data;
    logic              out_wr_en;
    logic              out_rd_en;
    logic [ADDR_W-1:0] out_rd_addr;
    logic [DW-1:0]     out_rd_data;

    logic [CNT_W-1:0] in_dec;
    logic [CNT_W-1:0] out_dec;
    logic             in_full;

    assign in_dec  = in_count_reg - CNT_W'(1);
    assign out_dec = out_count_reg - CNT_W'(1);
    assign in_full = (in_count_reg == CNT_W'(STACK_DEPTH));

    // Input stack: pushed at the top on enqueue, popped during a refill
    tsq_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_in_ram (
        .clk     (clk),
        .wr_en   (in_wr_en),
        .wr_addr (in_count_reg[ADDR_W-1:0]),
        .wr_data (req.value_in),
        .rd_en   (in_rd_en),
        .rd_addr (in_rd_addr),
        .rd_data (in_rd_data)
    );

    // Output stack: filled from the input stack, popped on dequeue
    tsq_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_out_ram (
        .clk     (clk),
        .wr_en   (out_wr_en),
        .wr_addr (out_count_reg[ADDR_W-1:0]),
        .wr_data (in_rd_data),
        .rd_en   (out_rd_en),
        .rd_addr (out_rd_addr),
        .rd_data (out_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsq_pkg::S_IDLE;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            pend_reg      <= pend_next;
            done_reg      <= done_next;
        end
    end

    // Result payload: no reset, qualified by done
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        pend_next      = pend_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        in_wr_en       = 1'b0;
        in_rd_en       = 1'b0;
        in_rd_addr     = in_dec[ADDR_W-1:0];
        out_wr_en      = 1'b0;
        out_rd_en      = 1'b0;
        out_rd_addr    = out_dec[ADDR_W-1:0];

        case (state_reg)
            tsq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (req.command == tsq_pkg::CMD_ENQ)
                    begin
                        // Push, or refuse when the input stack is full
                        done_next          = 1'b1;
                        rsp_next.value_out = '0;
                        if (in_full)
                        begin
                            rsp_next.status = tsq_pkg::ST_FULL;
                        end
                        else
                        begin
                            rsp_next.status = tsq_pkg::ST_OK;
                            in_wr_en        = 1'b1;
                            in_count_next   = in_count_reg + CNT_W'(1);
                        end
                    end
                    else if (out_count_reg != '0)
                    begin
                        // Pop straight from the output stack
                        out_rd_en      = 1'b1;
                        out_count_next = out_dec;
                        state_next     = tsq_pkg::S_POP;
                    end
                    else if (in_count_reg != '0)
                    begin
                        // Output stack dry: refill it first
                        pend_next  = 1'b0;
                        state_next = tsq_pkg::S_MOVE;
                    end
                    else
                    begin
                        done_next          = 1'b1;
                        rsp_next.value_out = '0;
                        rsp_next.status    = tsq_pkg::ST_EMPTY;
                    end
                end
            end

            tsq_pkg::S_MOVE:
            begin
                // Write the word read last cycle, read the next one
                if (pend_reg)
                begin
                    out_wr_en      = 1'b1;
                    out_count_next = out_count_reg + CNT_W'(1);
                end
                if (in_count_reg != '0)
                begin
                    in_rd_en      = 1'b1;
                    in_count_next = in_dec;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = tsq_pkg::S_POP_ADDR;
                end
            end

            tsq_pkg::S_POP_ADDR:
            begin
                out_rd_en      = 1'b1;
                out_count_next = out_dec;
                state_next     = tsq_pkg::S_POP;
            end

            tsq_pkg::S_POP:
            begin
                done_next          = 1'b1;
                rsp_next.value_out = out_rd_data;
                rsp_next.status    = tsq_pkg::ST_OK;
                state_next         = tsq_pkg::S_IDLE;
            end

            default:
            begin
                state_next = tsq_pkg::S_IDLE;
            end
        endcase

        if (done_next)
        begin
            rsp_next.now_empty = (in_count_next == '0) && (out_count_next == '0);
        end
    end

    assign busy = (state_reg != tsq_pkg::S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Input stack never holds more than its depth
    a_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(in_count_reg) <= STACK_DEPTH)
        else $error("input stack count beyond depth");

    // A refill never overruns the output stack
    a_move_fit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tsq_pkg::S_MOVE |->
            int'(in_count_reg) + int'(out_count_reg) <= STACK_DEPTH)
        else $error("refill would overrun output stack");

    // An accepted enqueue answers in the next cycle
    a_enq_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.command == tsq_pkg::CMD_ENQ |=> done)
        else $error("enqueue result missing");

    // A refused dequeue reports the queue empty
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == tsq_pkg::ST_EMPTY |-> rsp.now_empty)
        else $error("empty status without empty flag");

    // Refused requests return a zero word
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != tsq_pkg::ST_OK |-> rsp.value_out == '0)
        else $error("refused request returned data");

endmodule
